// ----- design/adctw_pkg.sv -----
// ----------------------------------------------------------------------------
// adctw_pkg: shared types and constants for the two-wire ADC master
// Holds the request and result payload structs, the controller state, and
// the data line drive pattern used during configuration transfers.
// ----------------------------------------------------------------------------
package adctw_pkg;

    localparam int SAMPLE_BITS = 24;

    localparam logic [5:0] SAMPLE_PULSE_LAST = 6'(SAMPLE_BITS);
    localparam logic [5:0] RESERVED_PULSE    = 6'(SAMPLE_BITS + 2);
    localparam logic [5:0] CAP_PULSES        = 6'(SAMPLE_BITS + 3);

    localparam logic [5:0] CFG_FLUSH         = 6'd27;
    localparam logic [5:0] CFG_PREAMBLE_END  = 6'd29;
    localparam logic [5:0] CFG_CMD_END       = 6'd36;
    localparam logic [5:0] CFG_SWITCH        = 6'd37;
    localparam logic [5:0] CFG_DATA_END      = 6'd45;
    localparam logic [5:0] CFG_PULSES        = 6'd46;

    localparam logic [6:0] CMD_READ          = 7'h56;
    localparam logic [6:0] CMD_WRITE         = 7'h65;
    localparam logic [7:0] WRITE_REJECT_MASK = 8'h83;

    // Bits above the sample width that get filled on a negative sample.
    localparam logic [23:0] SIGN_EXT_MASK = 24'(32'h00FF_FFFF << SAMPLE_BITS);

    typedef enum logic [2:0] {
        REQ_STEP      = 3'd0,
        REQ_CAPTURE   = 3'd1,
        REQ_CFG_READ  = 3'd2,
        REQ_CFG_WRITE = 3'd3,
        REQ_CLEAR     = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CAPTURE   = 2'd1,
        MODE_CFG_READ  = 2'd2,
        MODE_CFG_WRITE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DESYNC   = 2'd1,
        ERR_TOO_LONG = 2'd2
    } err_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       dio_level;
        logic       late_read;
        logic [7:0] config_value;
    } adctw_in_t;

    typedef struct packed {
        logic               sclk_pulse;
        logic               dio_drive_level;
        logic               dio_drive_enable;
        logic               busy_res;
        logic               sample_valid;
        logic signed [23:0] sample_value;
        logic [1:0]         sample_status;
        logic               config_done;
        logic               config_ok;
        logic [7:0]         config_readback;
    } adctw_out_t;

    typedef struct packed {
        mode_t       mode;
        logic [5:0]  pulse_count;
        logic [23:0] data_shift;
        logic [1:0]  sticky_error;
        logic        late_pending;
        logic        frame_bad;
        logic [7:0]  write_byte;
    } adctw_state_t;

    typedef struct packed {
        logic lvl;
        logic en;
    } drive_t;

    // Data line drive for configuration pulse p (1 to 46).
    function automatic drive_t cfg_drive(input logic is_write, input logic [5:0] p,
                                         input logic [7:0] val);
        drive_t     d;
        logic [6:0] cmd;
        cmd = is_write ? CMD_WRITE : CMD_READ;
        d   = '0;
        if (p > CFG_FLUSH && p < CFG_PULSES)
        begin
            if (p <= CFG_PREAMBLE_END)
            begin
                d.en  = 1'b1;
                d.lvl = 1'b1;
            end
            else if (p <= CFG_CMD_END)
            begin
                d.en  = 1'b1;
                d.lvl = cmd[3'(CFG_CMD_END - p)];
            end
            else if (p == CFG_SWITCH)
            begin
                if (is_write)
                begin
                    d.en  = 1'b1;
                    d.lvl = cmd[0];
                end
            end
            else if (is_write)
            begin
                d.en  = 1'b1;
                d.lvl = val[3'(CFG_DATA_END - p)];
            end
        end
        return d;
    endfunction

endpackage

// ----- design/adc_two_wire_sample_and_config.sv -----
// ----------------------------------------------------------------------------
// adc_two_wire_sample_and_config: two-wire sigma-delta ADC master
// An accepted request's result is in the output register in the next cycle.
// Throughput: one request per cycle, limited only by the result register
// draining. Reset clears the controller to idle with no error.
// A capture takes 28 requests (27 serial clocks, then the step that returns
// the sample); a config transfer takes 47 (46 serial clocks, then the end).
// ----------------------------------------------------------------------------
module adc_two_wire_sample_and_config
    import adctw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  adctw_in_t  req_data,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output adctw_out_t rsp_data
);

    adctw_state_t state_reg;
    adctw_state_t state_next;
    adctw_out_t   result;
    adctw_out_t   rsp_data_reg;
    logic         rsp_valid_reg;
    logic         accept;

    // A new request may enter whenever the result register is free or draining.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    adctw_step u_step (
        .state      (state_reg),
        .item       (req_data),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{mode: MODE_IDLE, default: '0};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_data_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ----- design/adctw_step.sv -----
// ----------------------------------------------------------------------------
// adctw_step: one serial clock step of the ADC master
// Combinational next state and result for one request, from the current
// controller state and the request fields.
// ----------------------------------------------------------------------------
module adctw_step
    import adctw_pkg::*;
(
    input  adctw_state_t state,
    input  adctw_in_t    item,
    output adctw_state_t state_next,
    output adctw_out_t   result
);

    mode_t       mode_next;
    logic [5:0]  p;
    logic        cap_end;
    logic        cfg_end;
    logic        cap_reject;
    logic        cfg_reject;
    logic        is_write;
    logic [23:0] cap_shift;
    logic        cap_frame_bad;
    logic [1:0]  cap_err;
    logic [23:0] cap_sample;
    drive_t      drv;

    assign p          = state.pulse_count;
    assign cap_end    = (p >= CAP_PULSES);
    assign cfg_end    = (p >= CFG_PULSES);
    assign cap_reject = item.dio_level || (state.sticky_error != ERR_NONE);
    assign cfg_reject = item.dio_level ||
                        ((item.req_type == REQ_CFG_WRITE) &&
                         ((item.config_value & WRITE_REJECT_MASK) != 8'd0));
    assign is_write   = (state.mode == MODE_CFG_WRITE);

    // Capture datapath: shift during data pulses, frame check on the last two.
    always_comb
    begin
        cap_shift     = state.data_shift;
        cap_frame_bad = state.frame_bad;
        if (p <= SAMPLE_PULSE_LAST)
            cap_shift = {state.data_shift[22:0], item.dio_level};
        else if (p == RESERVED_PULSE && item.dio_level)
            cap_frame_bad = 1'b1;
        else if (p == CAP_PULSES && !item.dio_level)
            cap_frame_bad = 1'b1;

        cap_err = state.sticky_error;
        if (cap_frame_bad)
            cap_err = ERR_DESYNC;
        if (state.late_pending)
            cap_err = ERR_TOO_LONG;

        cap_sample = cap_shift;
        if (cap_shift[SAMPLE_BITS-1])
            cap_sample = cap_shift | SIGN_EXT_MASK;
    end

    // Next state of the controller.
    always_comb
    begin
        mode_next = state.mode;
        unique case (state.mode)
            MODE_IDLE:
            begin
                unique case (item.req_type)
                    REQ_CAPTURE:   if (!cap_reject) mode_next = MODE_CAPTURE;
                    REQ_CFG_READ:  if (!cfg_reject) mode_next = MODE_CFG_READ;
                    REQ_CFG_WRITE: if (!cfg_reject) mode_next = MODE_CFG_WRITE;
                    default:       mode_next = MODE_IDLE;
                endcase
            end
            MODE_CAPTURE:
            begin
                if (cap_end)
                    mode_next = MODE_IDLE;
            end
            MODE_CFG_READ, MODE_CFG_WRITE:
            begin
                if (cfg_end)
                    mode_next = MODE_IDLE;
            end
        endcase
    end

    // Datapath updates and result fields.
    always_comb
    begin
        state_next      = state;
        state_next.mode = mode_next;
        result          = '0;
        drv             = '0;

        unique case (state.mode)
            MODE_IDLE:
            begin
                unique case (item.req_type)
                    REQ_CAPTURE:
                    begin
                        if (cap_reject)
                        begin
                            // No pulses: report the sticky error at once.
                            state_next.sticky_error = item.late_read ? ERR_TOO_LONG :
                                                      (item.dio_level ? ERR_DESYNC :
                                                       state.sticky_error);
                            result.sample_valid  = 1'b1;
                            result.sample_status = state_next.sticky_error;
                        end
                        else
                        begin
                            state_next.pulse_count  = 6'd1;
                            state_next.data_shift   = '0;
                            state_next.frame_bad    = 1'b0;
                            state_next.late_pending = item.late_read;
                            result.sclk_pulse       = 1'b1;
                        end
                    end
                    REQ_CFG_READ, REQ_CFG_WRITE:
                    begin
                        if (cfg_reject)
                            result.config_done = 1'b1;
                        else
                        begin
                            state_next.pulse_count = 6'd1;
                            state_next.data_shift  = '0;
                            state_next.write_byte  = (item.req_type == REQ_CFG_WRITE) ?
                                                     item.config_value : 8'd0;
                            result.sclk_pulse      = 1'b1;
                            drv = cfg_drive(item.req_type == REQ_CFG_WRITE, 6'd1,
                                            state_next.write_byte);
                        end
                    end
                    REQ_CLEAR:
                    begin
                        state_next.sticky_error = ERR_NONE;
                        state_next.late_pending = 1'b0;
                        state_next.frame_bad    = 1'b0;
                    end
                    default:
                    begin
                        state_next.sticky_error = state.sticky_error;
                    end
                endcase
            end
            MODE_CAPTURE:
            begin
                state_next.data_shift = cap_shift;
                state_next.frame_bad  = cap_frame_bad;
                if (cap_end)
                begin
                    state_next.sticky_error = cap_err;
                    state_next.pulse_count  = 6'd0;
                    state_next.late_pending = 1'b0;
                    state_next.frame_bad    = 1'b0;
                    result.sample_valid     = 1'b1;
                    result.sample_status    = cap_err;
                    result.sample_value     = (cap_err != ERR_NONE) ? 24'sd0 :
                                              $signed(cap_sample);
                end
                else
                begin
                    state_next.pulse_count = p + 6'd1;
                    result.sclk_pulse      = 1'b1;
                end
            end
            MODE_CFG_READ, MODE_CFG_WRITE:
            begin
                if (!is_write && p > CFG_SWITCH && p <= CFG_DATA_END)
                    state_next.data_shift = {16'd0, state.data_shift[6:0], item.dio_level};
                if (cfg_end)
                begin
                    state_next.pulse_count = 6'd0;
                    result.config_done     = 1'b1;
                    result.config_ok       = item.dio_level;
                    result.config_readback = (item.dio_level && !is_write) ?
                                             state.data_shift[7:0] : 8'd0;
                end
                else
                begin
                    state_next.pulse_count = p + 6'd1;
                    result.sclk_pulse      = 1'b1;
                    drv = cfg_drive(is_write, p + 6'd1, state.write_byte);
                end
            end
        endcase

        result.dio_drive_level  = drv.lvl;
        result.dio_drive_enable = drv.en;
        result.busy_res         = (mode_next != MODE_IDLE);
    end

endmodule

// ----- design/adctw_check.sv -----
// ----------------------------------------------------------------------------
// adctw_check: port-level checks for the two-wire ADC master
// Watches the result channel for handshake stability and for result
// fields that contradict each other.
// ----------------------------------------------------------------------------
module adctw_check
    import adctw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input adctw_out_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.sample_valid && rsp_data.config_done))
        else $error("sample and config completion in one result");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.sample_valid || rsp_data.config_done)
            |-> !rsp_data.busy_res && !rsp_data.sclk_pulse)
        else $error("transfer end still shows a pulse or busy");

    a_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.sample_valid
            |-> rsp_data.sample_status == ERR_NONE && rsp_data.sample_value == 24'sd0)
        else $error("sample fields set without a finished capture");

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.dio_drive_enable |-> rsp_data.busy_res && rsp_data.sclk_pulse)
        else $error("data line driven outside a transfer pulse");

endmodule

bind adc_two_wire_sample_and_config adctw_check u_adctw_check (.*);

// ----- dv/adctw_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adctw_tb_pkg: request tracker for the two-wire ADC master testbench
// Mirrors the serial controller step by step. Each accepted request is turned
// into the result that the block must return, and each returned result is
// compared field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
package adctw_tb_pkg;

    import adctw_pkg::*;

    class adc_step_tracker;

        // Mirrored controller state.
        mode_t       mode        = MODE_IDLE;
        int          pulse_cnt   = 0;
        logic [23:0] shift_reg   = '0;
        err_t        sticky      = ERR_NONE;
        logic        late_pend   = 1'b0;
        logic        frame_err   = 1'b0;
        logic [7:0]  wr_byte     = '0;

        adctw_out_t  step_results_q[$];
        int          mismatches  = 0;
        int          results_seen = 0;

        task report(input string msg);
            $display("MISMATCH result %0d: %s", results_seen, msg);
            mismatches++;
        endtask

        function int outstanding();
            return step_results_q.size();
        endfunction

        // Data line drive for configuration pulse p.
        function void line_drive(input logic wr, input int p, input logic [7:0] val,
                                 output logic lvl, output logic en);
            logic [6:0] cmd;
            cmd = wr ? CMD_WRITE : CMD_READ;
            lvl = 1'b0;
            en  = 1'b0;
            if (p > CFG_FLUSH && p <= CFG_PREAMBLE_END)
            begin
                en  = 1'b1;
                lvl = 1'b1;
            end
            else if (p > CFG_PREAMBLE_END && p <= CFG_CMD_END)
            begin
                en  = 1'b1;
                lvl = cmd[CFG_CMD_END - p];
            end
            else if (p == CFG_SWITCH)
            begin
                en  = wr;
                lvl = wr & cmd[0];
            end
            else if (wr && p > CFG_SWITCH && p <= CFG_DATA_END)
            begin
                en  = 1'b1;
                lvl = val[CFG_DATA_END - p];
            end
        endfunction

        function void note_request(input adctw_in_t r);
            adctw_out_t  o;
            int          p;
            logic [23:0] s;
            logic        wr;
            logic        lvl;
            logic        en;
            o   = '0;
            lvl = 1'b0;
            en  = 1'b0;
            p   = pulse_cnt;
            if (mode == MODE_IDLE)
            begin
                if (r.req_type == REQ_CAPTURE)
                begin
                    if (r.dio_level)
                        sticky = ERR_DESYNC;
                    if (sticky != ERR_NONE)
                    begin
                        // An error is already latched, so no pulses go out.
                        if (r.late_read)
                            sticky = ERR_TOO_LONG;
                        o.sample_valid  = 1'b1;
                        o.sample_status = sticky;
                    end
                    else
                    begin
                        mode         = MODE_CAPTURE;
                        pulse_cnt    = 1;
                        shift_reg    = '0;
                        frame_err    = 1'b0;
                        late_pend    = r.late_read;
                        o.sclk_pulse = 1'b1;
                    end
                end
                else if (r.req_type == REQ_CFG_READ || r.req_type == REQ_CFG_WRITE)
                begin
                    wr = (r.req_type == REQ_CFG_WRITE);
                    if (r.dio_level || (wr && (r.config_value & WRITE_REJECT_MASK) != '0))
                        o.config_done = 1'b1;
                    else
                    begin
                        mode         = wr ? MODE_CFG_WRITE : MODE_CFG_READ;
                        pulse_cnt    = 1;
                        shift_reg    = '0;
                        wr_byte      = wr ? r.config_value : 8'h00;
                        o.sclk_pulse = 1'b1;
                        line_drive(wr, 1, wr_byte, lvl, en);
                    end
                end
                else if (r.req_type == REQ_CLEAR)
                begin
                    sticky    = ERR_NONE;
                    late_pend = 1'b0;
                    frame_err = 1'b0;
                end
            end
            else if (mode == MODE_CAPTURE)
            begin
                if (p <= SAMPLE_BITS)
                    shift_reg = {shift_reg[22:0], r.dio_level};
                else if (p == SAMPLE_BITS + 2 && r.dio_level)
                    frame_err = 1'b1;
                else if (p == SAMPLE_BITS + 3 && !r.dio_level)
                    frame_err = 1'b1;
                if (p >= CAP_PULSES)
                begin
                    s = shift_reg;
                    if (frame_err)
                        sticky = ERR_DESYNC;
                    if (late_pend)
                        sticky = ERR_TOO_LONG;
                    if (s[SAMPLE_BITS-1])
                        s = s | (24'hFF_FFFF << SAMPLE_BITS);
                    o.sample_valid  = 1'b1;
                    o.sample_status = sticky;
                    o.sample_value  = (sticky != ERR_NONE) ? 24'sd0 : s;
                    mode      = MODE_IDLE;
                    pulse_cnt = 0;
                    late_pend = 1'b0;
                    frame_err = 1'b0;
                end
                else
                begin
                    pulse_cnt    = p + 1;
                    o.sclk_pulse = 1'b1;
                end
            end
            else
            begin
                wr = (mode == MODE_CFG_WRITE);
                if (!wr && p > CFG_SWITCH && p <= CFG_DATA_END)
                    shift_reg = {shift_reg[22:0], r.dio_level};
                if (p >= CFG_PULSES)
                begin
                    o.config_done     = 1'b1;
                    o.config_ok       = r.dio_level;
                    o.config_readback = (r.dio_level && !wr) ? shift_reg[7:0] : 8'h00;
                    mode      = MODE_IDLE;
                    pulse_cnt = 0;
                end
                else
                begin
                    pulse_cnt    = p + 1;
                    o.sclk_pulse = 1'b1;
                    line_drive(wr, p + 1, wr_byte, lvl, en);
                end
            end
            o.dio_drive_level  = lvl;
            o.dio_drive_enable = en;
            o.busy_res         = (mode != MODE_IDLE);
            step_results_q.push_back(o);
        endfunction

        task compare_field(input string name, input logic [23:0] got, input logic [23:0] exp);
            if (got !== exp)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp));
        endtask

        task check_result(input adctw_out_t got);
            adctw_out_t exp;
            results_seen++;
            if (step_results_q.size() == 0)
            begin
                report("result returned with no request outstanding");
                return;
            end
            exp = step_results_q.pop_front();
            compare_field("sclk_pulse", 24'(got.sclk_pulse), 24'(exp.sclk_pulse));
            compare_field("dio_drive_level", 24'(got.dio_drive_level),
                          24'(exp.dio_drive_level));
            compare_field("dio_drive_enable", 24'(got.dio_drive_enable),
                          24'(exp.dio_drive_enable));
            compare_field("busy_res", 24'(got.busy_res), 24'(exp.busy_res));
            compare_field("sample_valid", 24'(got.sample_valid), 24'(exp.sample_valid));
            compare_field("sample_value", got.sample_value, exp.sample_value);
            compare_field("sample_status", 24'(got.sample_status), 24'(exp.sample_status));
            compare_field("config_done", 24'(got.config_done), 24'(exp.config_done));
            compare_field("config_ok", 24'(got.config_ok), 24'(exp.config_ok));
            compare_field("config_readback", 24'(got.config_readback),
                          24'(exp.config_readback));
        endtask

    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the two-wire ADC master
// Drives requests through the valid/ready channel with random gaps and result
// stalls, predicts every result in a tracker and checks it field by field.
// A directed opening hits rejects and error paths, then random captures,
// config transfers and noise follow.
// ----------------------------------------------------------------------------
module tb_top;

    import adctw_pkg::*;
    import adctw_tb_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_TAIL    = 850;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    adctw_in_t  req_data  = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    adctw_out_t rsp_data;

    adc_step_tracker tracker;
    int  items_sent  = 0;
    int  quiet_cycles = 0;
    int  stall_left  = 0;
    bit  gaps_on     = 1'b0;
    bit  stalls_on   = 1'b0;

    adc_two_wire_sample_and_config u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #2 clk = ~clk;

    // Result side: random stall bursts while enabled.
    always @(negedge clk)
    begin
        if (!stalls_on)
            rsp_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                tracker.check_result(rsp_data);
            if (req_valid && req_ready)
                tracker.note_request(req_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic adctw_in_t make_req(input logic [2:0] kind, input logic dio,
                                           input logic late, input logic [7:0] val);
        adctw_in_t r;
        r.req_type     = kind;
        r.dio_level    = dio;
        r.late_read    = late;
        r.config_value = val;
        return r;
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Request code used while a transfer runs; the block treats any code as a step.
    function automatic logic [2:0] step_kind();
        if ($urandom_range(0, 3) == 0)
            return 3'($urandom_range(0, 7));
        return REQ_STEP;
    endfunction

    // Called and returns at a falling edge; valid stays high between back-to-back requests.
    task automatic send_req(input adctw_in_t item);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic run_capture(input logic [23:0] word, input logic late,
                               input logic reserved_bit, input logic release_bit);
        int   p;
        logic dio;
        send_req(make_req(REQ_CAPTURE, 1'b0, late, 8'($urandom_range(0, 255))));
        for (p = 1; p <= CAP_PULSES; p++)
        begin
            if (p <= SAMPLE_BITS)
                dio = word[SAMPLE_BITS-p];
            else if (p == SAMPLE_BITS + 1)
                dio = coin();
            else if (p == SAMPLE_BITS + 2)
                dio = reserved_bit;
            else
                dio = release_bit;
            send_req(make_req(step_kind(), dio, coin(), 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic run_config(input logic wr, input logic [7:0] val,
                              input logic [7:0] reg_byte, input logic done_bit);
        int   p;
        logic dio;
        send_req(make_req(wr ? REQ_CFG_WRITE : REQ_CFG_READ, 1'b0, coin(), val));
        for (p = 1; p <= CFG_PULSES; p++)
        begin
            if (p > CFG_SWITCH && p <= CFG_DATA_END)
                dio = reg_byte[CFG_DATA_END - p];
            else if (p == CFG_PULSES)
                dio = done_bit;
            else
                dio = coin();
            send_req(make_req(step_kind(), dio, coin(), 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic run_noise(input int count);
        repeat (count)
            send_req(make_req(3'($urandom_range(0, 7)), coin(), coin(),
                              8'($urandom_range(0, 255))));
    endtask

    initial
    begin
        int          choice;
        logic        wr;
        logic [7:0]  val;
        logic [23:0] word;
        tracker = new;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: idle no-ops, unknown codes, error paths and rejects.
        stalls_on = 1'b1;
        send_req(make_req(REQ_STEP, 1'b0, 1'b0, 8'h00));
        send_req(make_req(3'd7, 1'b1, 1'b1, 8'hFF));
        send_req(make_req(3'd5, 1'b0, 1'b1, 8'h55));
        send_req(make_req(3'd6, 1'b1, 1'b0, 8'hAA));
        send_req(make_req(REQ_CLEAR, 1'b0, 1'b0, 8'h00));
        // Line not ready at a capture start latches desync.
        send_req(make_req(REQ_CAPTURE, 1'b1, 1'b0, 8'h00));
        // Late read on top of a latched error turns it into read-too-long.
        send_req(make_req(REQ_CAPTURE, 1'b0, 1'b1, 8'h00));
        send_req(make_req(REQ_CAPTURE, 1'b0, 1'b0, 8'h00));
        send_req(make_req(REQ_CLEAR, 1'b1, 1'b1, 8'hFF));
        send_req(make_req(REQ_CAPTURE, 1'b1, 1'b1, 8'h00));
        send_req(make_req(REQ_CLEAR, 1'b0, 1'b0, 8'h00));
        // Config rejects: line busy, and each bit of the write mask.
        send_req(make_req(REQ_CFG_READ, 1'b1, 1'b0, 8'h00));
        send_req(make_req(REQ_CFG_WRITE, 1'b1, 1'b0, 8'h7C));
        send_req(make_req(REQ_CFG_WRITE, 1'b0, 1'b0, 8'h80));
        send_req(make_req(REQ_CFG_WRITE, 1'b0, 1'b0, 8'h01));
        send_req(make_req(REQ_CFG_WRITE, 1'b0, 1'b0, 8'h02));
        send_req(make_req(REQ_CFG_WRITE, 1'b0, 1'b1, 8'hFF));
        drain_results();

        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent > CALM_TAIL)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            choice = $urandom_range(0, 99);
            if (choice < 45)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_req(make_req(REQ_CLEAR, coin(), coin(), 8'($urandom_range(0, 255))));
                case ($urandom_range(0, 7))
                    0:       word = 24'h7F_FFFF;
                    1:       word = 24'h80_0000;
                    2:       word = 24'h00_0000;
                    3:       word = 24'hFF_FFFF;
                    default: word = 24'($urandom());
                endcase
                run_capture(word, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                            $urandom_range(0, 9) != 0);
            end
            else if (choice < 75)
            begin
                wr  = coin();
                val = 8'($urandom_range(0, 255));
                if (wr && $urandom_range(0, 4) != 0)
                    val = val & ~WRITE_REJECT_MASK;
                run_config(wr, val, 8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
            end
            else if (choice < 96)
                run_noise($urandom_range(1, 8));
            else
                drain_results();
        end

        drain_results();
        repeat (5) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
